// File: src/kaa_pkg.sv
package kaa_pkg;

  // Default sizes of the tables.
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_DIMS     = 16;
  localparam int DEF_COORD_BITS   = 16;

  // Fixed field widths of the item ports.
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 32;
  localparam int SUM_W   = 48;

  // Configuration registers.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS     = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_NC_RESET     = 5'd16;
  localparam logic [CFG_W-1:0]     CFG_ND_RESET     = 5'd16;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic KIND_ASSIGN  = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

endpackage

// File: src/kaa_ram.sv
module kaa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/kmeans_assign_accumulate.sv
// Load (mode 0) is written at the accepting edge and leaves the block idle.
// A sample coordinate in an active dimension keeps busy high while one shared
// multiplier squares one centroid difference per cycle, over all MAX_CLUSTERS.
// The closing coordinate adds a minimum search over num_clusters and a sum
// update over num_dims; the result strobe follows. A readout strobes from the
// read state. Reset and clear sweep the MAX_CLUSTERS*MAX_DIMS sums, busy high.
module kmeans_assign_accumulate #(
  parameter int MAX_CLUSTERS = kaa_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = kaa_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS   = kaa_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [kaa_pkg::MODE_W-1:0]         in_mode,
  input  logic [kaa_pkg::IDX_W-1:0]          in_cluster,
  input  logic [kaa_pkg::IDX_W-1:0]          in_dim,
  input  logic signed [COORD_BITS-1:0]       in_coord,
  input  logic                               in_last,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic [kaa_pkg::IDX_W-1:0]          out_nearest,
  output logic [kaa_pkg::COUNT_W-1:0]        out_member_count,
  output logic signed [kaa_pkg::SUM_W-1:0]   out_coord_sum,
  input  logic                               cfg_we,
  input  logic [kaa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kaa_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int NE    = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW    = (NE > 1) ? $clog2(NE) : 1;
  localparam int CLW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DMW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int MAXN  = (MAX_CLUSTERS > MAX_DIMS) ? MAX_CLUSTERS : MAX_DIMS;
  localparam int CW    = $clog2(MAXN + 1);
  localparam int DW    = 2 * COORD_BITS + 6;
  localparam int SQW   = 2 * COORD_BITS;
  localparam int SUM_W = kaa_pkg::SUM_W;
  localparam int CNT_W = kaa_pkg::COUNT_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIST, S_MIN, S_ACC, S_READ} state_t;

  function automatic logic [AW-1:0] tab_addr(logic [CLW-1:0] k, logic [DMW-1:0] d);
    tab_addr = AW'(k) * AW'(MAX_DIMS) + AW'(d);
  endfunction

  state_t                   state_r;
  logic [CW-1:0]            idx_r;
  logic [kaa_pkg::CFG_W-1:0] cfg_nc_r, cfg_nd_r;
  logic [CW-1:0]            eff_nc, eff_nd;

  logic signed [COORD_BITS-1:0] coord_r;
  logic                     last_r;
  logic [DMW-1:0]           dm_r;
  logic [kaa_pkg::IDX_W-1:0] cl_r;
  logic                     rd_ok_r;

  logic [MAX_CLUSTERS-1:0]  pdv_r;
  logic                     s1_v_r, s2_v_r, s3_v_r;
  logic [CLW-1:0]           s1_k_r, s2_k_r, s3_k_r;
  logic [COORD_BITS-1:0]    mag_r;
  logic [DW-1:0]            acc2_r, acc3_r;
  logic [SQW-1:0]           sq_r;

  logic                     m_v_r;
  logic [CLW-1:0]           m_k_r, best_k_r;
  logic [DW-1:0]            best_d_r;

  logic                     a_v_r;
  logic [DMW-1:0]           a_d_r;
  logic [CNT_W-1:0]         cnt_new_r;

  logic [AW-1:0]            clr_a_r;
  logic [CLW-1:0]           clr_k_r;
  logic [DMW-1:0]           clr_d_r;

  logic                     out_valid_r, out_kind_r;
  logic [kaa_pkg::IDX_W-1:0] out_nearest_r;
  logic [CNT_W-1:0]         out_member_count_r;
  logic [SUM_W-1:0]         out_coord_sum_r;

  logic                     accept, clearing, idx_ok, dim_used;
  logic                     dist_issue, min_issue, acc_issue;
  logic [AW-1:0]            in_addr;

  logic signed [COORD_BITS-1:0] cen_rd, sbuf_rd;
  logic [DW-1:0]            pd_rd, pd_s1, m_dist, pd_new;
  logic [DW:0]              pd_add;
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS-1:0]    mag;
  logic [SQW-1:0]           sq_c;
  logic signed [SUM_W-1:0]  sum_rd;
  logic signed [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]         sum_sat;
  logic [CNT_W-1:0]         cnt_rd, cnt_inc;

  logic                     cen_we, sbuf_we, sum_we, cnt_we;
  logic [AW-1:0]            sum_waddr, sum_raddr;
  logic [CLW-1:0]           cnt_waddr, cnt_raddr;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign clearing = (state_r == S_CLEAR);

  // A register value of zero acts as one, and one above the maximum as the maximum.
  always_comb begin
    if (cfg_nc_r == '0) begin
      eff_nc = CW'(1);
    end else if (int'(cfg_nc_r) > MAX_CLUSTERS) begin
      eff_nc = CW'(MAX_CLUSTERS);
    end else begin
      eff_nc = CW'(cfg_nc_r);
    end
    if (cfg_nd_r == '0) begin
      eff_nd = CW'(1);
    end else if (int'(cfg_nd_r) > MAX_DIMS) begin
      eff_nd = CW'(MAX_DIMS);
    end else begin
      eff_nd = CW'(cfg_nd_r);
    end
  end

  assign idx_ok   = (int'(in_cluster) < MAX_CLUSTERS) && (int'(in_dim) < MAX_DIMS);
  assign dim_used = (int'(in_dim) < int'(eff_nd));
  assign in_addr  = tab_addr(CLW'(in_cluster), DMW'(in_dim));

  assign dist_issue = (state_r == S_DIST) && (idx_r < CW'(MAX_CLUSTERS));
  assign min_issue  = (state_r == S_MIN) && (idx_r < eff_nc);
  assign acc_issue  = (state_r == S_ACC) && (idx_r < eff_nd);

  // Distance unit: difference, square, saturating accumulate.
  assign diff   = {cen_rd[COORD_BITS-1], cen_rd} - {coord_r[COORD_BITS-1], coord_r};
  assign mag    = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
  assign pd_s1  = pdv_r[s1_k_r] ? pd_rd : '0;
  assign sq_c   = mag_r * mag_r;
  assign pd_add = {1'b0, acc3_r} + (DW+1)'(sq_r);
  assign pd_new = pd_add[DW] ? '1 : pd_add[DW-1:0];

  assign m_dist = pdv_r[m_k_r] ? pd_rd : '0;

  assign sum_add = (SUM_W+1)'(sum_rd) + (SUM_W+1)'(sbuf_rd);
  always_comb begin
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_sat = sum_add[SUM_W] ? kaa_pkg::SUM_MIN : kaa_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_add[SUM_W-1:0];
    end
  end
  assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

  assign cen_we  = accept && (kaa_pkg::mode_t'(in_mode) == kaa_pkg::MODE_LOAD) && idx_ok;
  assign sbuf_we = accept && (kaa_pkg::mode_t'(in_mode) == kaa_pkg::MODE_SAMPLE) && dim_used;

  assign sum_we    = clearing || a_v_r;
  assign sum_waddr = clearing ? clr_a_r : tab_addr(best_k_r, a_d_r);
  assign sum_raddr = (state_r == S_IDLE) ? in_addr : tab_addr(best_k_r, idx_r[DMW-1:0]);
  assign cnt_we    = clearing || (a_v_r && (a_d_r == '0));
  assign cnt_waddr = clearing ? clr_k_r : best_k_r;
  assign cnt_raddr = (state_r == S_IDLE) ? CLW'(in_cluster) : best_k_r;

  kaa_ram #(.WIDTH(COORD_BITS), .DEPTH(NE)) u_centroid (
    .clk     (clk),
    .we      (cen_we),
    .wr_addr (in_addr),
    .wr_data (in_coord),
    .rd_addr (tab_addr(idx_r[CLW-1:0], dm_r)),
    .rd_data (cen_rd)
  );

  kaa_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_DIMS)) u_sample (
    .clk     (clk),
    .we      (sbuf_we),
    .wr_addr (DMW'(in_dim)),
    .wr_data (in_coord),
    .rd_addr (idx_r[DMW-1:0]),
    .rd_data (sbuf_rd)
  );

  kaa_ram #(.WIDTH(DW), .DEPTH(MAX_CLUSTERS)) u_partial (
    .clk     (clk),
    .we      (s3_v_r),
    .wr_addr (s3_k_r),
    .wr_data (pd_new),
    .rd_addr (idx_r[CLW-1:0]),
    .rd_data (pd_rd)
  );

  kaa_ram #(.WIDTH(SUM_W), .DEPTH(NE)) u_sum (
    .clk     (clk),
    .we      (sum_we),
    .wr_addr (sum_waddr),
    .wr_data (clearing ? '0 : sum_sat),
    .rd_addr (sum_raddr),
    .rd_data (sum_rd)
  );

  kaa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLUSTERS)) u_count (
    .clk     (clk),
    .we      (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (clearing ? '0 : cnt_inc),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rd)
  );

  always_ff @(posedge clk) begin
    mag_r  <= mag;
    acc2_r <= pd_s1;
    sq_r   <= sq_c;
    acc3_r <= acc2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cfg_nc_r    <= kaa_pkg::CFG_NC_RESET;
      cfg_nd_r    <= kaa_pkg::CFG_ND_RESET;
      pdv_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      m_v_r       <= 1'b0;
      a_v_r       <= 1'b0;
      clr_a_r     <= '0;
      clr_k_r     <= '0;
      clr_d_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kaa_pkg::CFG_NUM_CLUSTERS: cfg_nc_r <= cfg_wdata;
          kaa_pkg::CFG_NUM_DIMS:     cfg_nd_r <= cfg_wdata;
          default: ;
        endcase
      end

      out_valid_r <= 1'b0;

      s1_v_r <= dist_issue;
      s1_k_r <= idx_r[CLW-1:0];
      s2_v_r <= s1_v_r;
      s2_k_r <= s1_k_r;
      s3_v_r <= s2_v_r;
      s3_k_r <= s2_k_r;
      if (s3_v_r) begin
        pdv_r[s3_k_r] <= 1'b1;
      end

      // Strict compare, so the lower index keeps a tie.
      m_v_r <= min_issue;
      m_k_r <= idx_r[CLW-1:0];
      if (m_v_r && ((m_k_r == '0) || (m_dist < best_d_r))) begin
        best_d_r <= m_dist;
        best_k_r <= m_k_r;
      end

      a_v_r <= acc_issue;
      a_d_r <= idx_r[DMW-1:0];
      if (a_v_r && (a_d_r == '0)) begin
        cnt_new_r <= cnt_inc;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_a_r <= clr_a_r + 1'b1;
          if (clr_d_r == DMW'(MAX_DIMS - 1)) begin
            clr_d_r <= '0;
            clr_k_r <= clr_k_r + 1'b1;
          end else begin
            clr_d_r <= clr_d_r + 1'b1;
          end
          if (clr_a_r == AW'(NE - 1)) begin
            clr_a_r <= '0;
            clr_k_r <= '0;
            clr_d_r <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            coord_r <= in_coord;
            last_r  <= in_last;
            dm_r    <= DMW'(in_dim);
            cl_r    <= in_cluster;
            rd_ok_r <= idx_ok;
            idx_r   <= '0;
            unique case (kaa_pkg::mode_t'(in_mode))
              kaa_pkg::MODE_LOAD: ;
              kaa_pkg::MODE_SAMPLE: begin
                if (dim_used) begin
                  state_r <= S_DIST;
                end else if (in_last) begin
                  state_r <= S_MIN;
                end
              end
              kaa_pkg::MODE_READ:  state_r <= S_READ;
              kaa_pkg::MODE_CLEAR: state_r <= S_CLEAR;
              default: ;
            endcase
          end
        end
        S_DIST: begin
          if (dist_issue) begin
            idx_r <= idx_r + 1'b1;
          end else if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            idx_r   <= '0;
            state_r <= last_r ? S_MIN : S_IDLE;
          end
        end
        S_MIN: begin
          if (min_issue) begin
            idx_r <= idx_r + 1'b1;
          end else if (!m_v_r) begin
            idx_r   <= '0;
            pdv_r   <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_issue) begin
            idx_r <= idx_r + 1'b1;
          end else if (!a_v_r) begin
            idx_r              <= '0;
            state_r            <= S_IDLE;
            out_valid_r        <= 1'b1;
            out_kind_r         <= kaa_pkg::KIND_ASSIGN;
            out_nearest_r      <= kaa_pkg::IDX_W'(best_k_r);
            out_member_count_r <= cnt_new_r;
            out_coord_sum_r    <= '0;
          end
        end
        S_READ: begin
          state_r            <= S_IDLE;
          out_valid_r        <= 1'b1;
          out_kind_r         <= kaa_pkg::KIND_READOUT;
          out_nearest_r      <= cl_r;
          out_member_count_r <= rd_ok_r ? cnt_rd : '0;
          out_coord_sum_r    <= rd_ok_r ? sum_rd : '0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_nearest      = out_nearest_r;
  assign out_member_count = out_member_count_r;
  assign out_coord_sum    = out_coord_sum_r;

  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_dist_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r || s3_v_r) |-> (state_r == S_DIST))
    else $error("distance pipeline active outside distance phase");

  a_partial_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (pdv_r == '0))
    else $error("partial distances not cleared when sample closed");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import kaa_pkg::*;

  localparam int NCL = DEF_MAX_CLUSTERS;
  localparam int NDM = DEF_MAX_DIMS;
  localparam int CBITS = DEF_COORD_BITS;
  localparam longint DIST_LIM = (64'sd1 <<< (2 * CBITS + 6)) - 1;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 62;

  typedef struct packed {
    logic kind;
    logic [IDX_W-1:0] nearest;
    logic [COUNT_W-1:0] member_count;
    logic signed [SUM_W-1:0] coord_sum;
  } report_t;

  typedef struct packed {
    bit is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0] reg_val;
    mode_t mode;
    logic [IDX_W-1:0] cluster;
    logic [IDX_W-1:0] dim;
    logic signed [CBITS-1:0] coord;
    logic last;
    bit typed;
    report_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [IDX_W-1:0] in_cluster = '0;
  logic [IDX_W-1:0] in_dim = '0;
  logic signed [CBITS-1:0] in_coord = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_kind;
  logic [IDX_W-1:0] out_nearest;
  logic [COUNT_W-1:0] out_member_count;
  logic signed [SUM_W-1:0] out_coord_sum;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  kmeans_assign_accumulate uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_cluster(in_cluster), .in_dim(in_dim),
    .in_coord(in_coord), .in_last(in_last),
    .out_valid(out_valid), .out_kind(out_kind), .out_nearest(out_nearest),
    .out_member_count(out_member_count), .out_coord_sum(out_coord_sum),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the clustering state.
  logic signed [CBITS-1:0] centroid_q [NCL*NDM];
  logic signed [CBITS-1:0] seen_coord [NDM];
  longint dist_acc [NCL];
  longint sum_acc [NCL*NDM];
  logic [COUNT_W-1:0] tally [NCL];
  logic [CFG_W-1:0] clusters_reg;
  logic [CFG_W-1:0] dims_reg;

  report_t cluster_reports [$];
  report_t typed_report;
  bit typed_on = 1'b0;
  bit idling_on = 1'b1;
  int fail_count = 0;
  int stall_cycles = 0;

  function automatic int eff_size(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < NCL * NDM; i++) begin
      centroid_q[i] = '0;
      sum_acc[i] = 0;
    end
    for (int i = 0; i < NDM; i++) seen_coord[i] = '0;
    for (int k = 0; k < NCL; k++) begin
      dist_acc[k] = 0;
      tally[k] = '0;
    end
    clusters_reg = CFG_NC_RESET;
    dims_reg = CFG_ND_RESET;
  endfunction

  // Applies one item to the shadow state; returns 1 when it yields a report.
  function automatic bit assign_accumulate(input logic [MODE_W-1:0] m,
                                           input logic [IDX_W-1:0] cl,
                                           input logic [IDX_W-1:0] dm,
                                           input logic signed [CBITS-1:0] cv,
                                           input logic lst,
                                           output report_t rep);
    int dims;
    int clusters;
    int best;
    longint diff;
    longint mag;
    longint sq;
    longint s;
    dims = eff_size(dims_reg);
    clusters = eff_size(clusters_reg);
    rep = '0;
    case (mode_t'(m))
      MODE_LOAD: begin
        centroid_q[cl * NDM + dm] = cv;
        return 1'b0;
      end
      MODE_SAMPLE: begin
        if (dm < dims) begin
          seen_coord[dm] = cv;
          for (int k = 0; k < NCL; k++) begin
            diff = longint'(centroid_q[k * NDM + dm]) - longint'(cv);
            mag = (diff < 0) ? -diff : diff;
            sq = mag * mag;
            if (sq > DIST_LIM || dist_acc[k] > DIST_LIM - sq) dist_acc[k] = DIST_LIM;
            else dist_acc[k] = dist_acc[k] + sq;
          end
        end
        if (!lst) return 1'b0;
        best = 0;
        for (int k = 1; k < clusters; k++)
          if (dist_acc[k] < dist_acc[best]) best = k;
        if (tally[best] != '1) tally[best] = tally[best] + 1;
        for (int d = 0; d < dims; d++) begin
          s = sum_acc[best * NDM + d] + longint'(seen_coord[d]);
          if (s > SUM_HI) s = SUM_HI;
          if (s < SUM_LO) s = SUM_LO;
          sum_acc[best * NDM + d] = s;
        end
        for (int k = 0; k < NCL; k++) dist_acc[k] = 0;
        rep.kind = KIND_ASSIGN;
        rep.nearest = best[IDX_W-1:0];
        rep.member_count = tally[best];
        return 1'b1;
      end
      MODE_READ: begin
        rep.kind = KIND_READOUT;
        rep.nearest = cl;
        rep.member_count = tally[cl];
        rep.coord_sum = sum_acc[cl * NDM + dm][SUM_W-1:0];
        return 1'b1;
      end
      default: begin
        for (int i = 0; i < NCL * NDM; i++) sum_acc[i] = 0;
        for (int k = 0; k < NCL; k++) tally[k] = '0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    report_t predicted;
    report_t want;
    bit made;
    if (!rst_n) begin
      clear_model();
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (out_valid) begin
        stall_cycles = 0;
        if (cluster_reports.size() == 0) begin
          $error("result with nothing expected: kind %0d nearest %0d", out_kind, out_nearest);
          fail_count++;
        end else begin
          want = cluster_reports.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("nearest", want.nearest, out_nearest);
          check_field("member_count", want.member_count, out_member_count);
          check_field("coord_sum", want.coord_sum, out_coord_sum);
        end
      end
      if (cfg_we) begin
        stall_cycles = 0;
        if (cfg_index == CFG_NUM_CLUSTERS) clusters_reg = cfg_wdata;
        else dims_reg = cfg_wdata;
      end
      if (start && !busy) begin
        stall_cycles = 0;
        made = assign_accumulate(in_mode, in_cluster, in_dim, in_coord, in_last, predicted);
        if (made) cluster_reports.push_back(typed_on ? typed_report : predicted);
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [IDX_W-1:0] rnd4();
    logic [31:0] r;
    r = $urandom;
    return r[IDX_W-1:0];
  endfunction

  function automatic logic signed [CBITS-1:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return r[CBITS-1:0];
    endcase
  endfunction

  task automatic send_item(input mode_t m, input logic [IDX_W-1:0] cl,
                           input logic [IDX_W-1:0] dm, input logic signed [CBITS-1:0] cv,
                           input logic lst, input bit has_typed, input report_t typed);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    in_mode = m;
    in_cluster = cl;
    in_dim = dm;
    in_coord = cv;
    in_last = lst;
    typed_on = has_typed;
    typed_report = typed;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds off new items until every report is in and the block has gone quiet.
  task automatic drain_block();
    @(negedge clk);
    start = 1'b0;
    while (cluster_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic step_t item_row(input mode_t m, input logic [IDX_W-1:0] cl,
                                     input logic [IDX_W-1:0] dm,
                                     input logic signed [CBITS-1:0] cv, input logic lst);
    step_t row;
    row = '0;
    row.mode = m;
    row.cluster = cl;
    row.dim = dm;
    row.coord = cv;
    row.last = lst;
    return row;
  endfunction

  function automatic step_t read_row(input logic [IDX_W-1:0] cl, input logic [IDX_W-1:0] dm,
                                     input logic [COUNT_W-1:0] cnt,
                                     input logic signed [SUM_W-1:0] total);
    step_t row;
    row = item_row(MODE_READ, cl, dm, '0, 1'b1);
    row.typed = 1'b1;
    row.want.kind = KIND_READOUT;
    row.want.nearest = cl;
    row.want.member_count = cnt;
    row.want.coord_sum = total;
    return row;
  endfunction

  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    step_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  initial begin
    step_t script [$];
    step_t row;
    logic [CFG_W-1:0] nc_val;
    logic [CFG_W-1:0] nd_val;
    int dims;
    int sent;
    int n;
    int rot;
    int r;
    bit long_done;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    drain_block();

    // Fill the whole centroid table so that no sample ever meets an unwritten
    // entry; centroid k sits at k.0 in every dimension.
    for (int k = 0; k < NCL; k++)
      for (int d = 0; d < NDM; d++)
        send_item(MODE_LOAD, k, d, CBITS'(k * 256), $urandom_range(0, 1), 1'b0, '0);
    // One full sample at 3.0 writes every entry of the sample buffer.
    for (int d = 0; d < NDM; d++)
      send_item(MODE_SAMPLE, rnd4(), d, 16'sd768, d == NDM - 1, 1'b0, '0);

    script.push_back(read_row(0, 0, 0, 0));
    script.push_back(read_row(3, 15, 1, 768));
    script.push_back(item_row(MODE_SAMPLE, 15, 0, 16'sh7FFF, 1'b0));
    script.push_back(item_row(MODE_SAMPLE, 15, 1, 16'sh8000, 1'b0));
    script.push_back(item_row(MODE_SAMPLE, 0, 15, 16'sh0000, 1'b1));
    script.push_back(item_row(MODE_LOAD, 15, 15, 16'sh7FFF, 1'b1));
    script.push_back(item_row(MODE_LOAD, 0, 0, 16'sh8000, 1'b0));
    script.push_back(item_row(MODE_SAMPLE, 0, 0, 16'sh0000, 1'b1));
    script.push_back(cfg_row(CFG_NUM_DIMS, 4));
    // A coordinate beyond the active dimensions is dropped but still closes
    // the sample, so every distance is zero and centroid 0 wins.
    script.push_back(item_row(MODE_SAMPLE, 0, 9, 16'sd1234, 1'b1));
    script.push_back(cfg_row(CFG_NUM_DIMS, 0));
    script.push_back(item_row(MODE_SAMPLE, 0, 1, 16'sd500, 1'b0));
    script.push_back(item_row(MODE_SAMPLE, 0, 0, 16'sd500, 1'b1));
    script.push_back(cfg_row(CFG_NUM_CLUSTERS, 0));
    script.push_back(item_row(MODE_SAMPLE, 0, 0, -16'sd7, 1'b1));
    script.push_back(cfg_row(CFG_NUM_CLUSTERS, 31));
    script.push_back(cfg_row(CFG_NUM_DIMS, 31));
    script.push_back(item_row(MODE_CLEAR, 0, 0, 16'sh0000, 1'b1));
    script.push_back(read_row(0, 0, 0, 0));
    script.push_back(read_row(3, 0, 0, 0));
    // A clear in the middle of a sample leaves the partial distances alone.
    script.push_back(item_row(MODE_SAMPLE, 0, 2, 16'sd100, 1'b0));
    script.push_back(item_row(MODE_CLEAR, 0, 0, 16'sh0000, 1'b0));
    script.push_back(item_row(MODE_SAMPLE, 0, 3, 16'sd100, 1'b1));
    script.push_back(cfg_row(CFG_NUM_CLUSTERS, 2));
    script.push_back(cfg_row(CFG_NUM_DIMS, 1));
    // Equal distances to both centroids: the lower index must win.
    script.push_back(item_row(MODE_LOAD, 0, 0, 16'sd256, 1'b0));
    script.push_back(item_row(MODE_LOAD, 1, 0, -16'sd256, 1'b0));
    script.push_back(item_row(MODE_SAMPLE, 0, 0, 16'sh0000, 1'b1));

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        drain_block();
        write_cfg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.mode, row.cluster, row.dim, row.coord, row.last, row.typed, row.want);
      end
    end

    long_done = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain_block();
      case (p)
        0: begin nc_val = 16; nd_val = 16; end
        1: begin nc_val = 1; nd_val = 1; end
        2: begin nc_val = 0; nd_val = 0; end
        3: begin nc_val = 31; nd_val = 17; end
        default: begin
          nc_val = $urandom_range(0, 31);
          nd_val = $urandom_range(0, 31);
        end
      endcase
      write_cfg(CFG_NUM_CLUSTERS, nc_val);
      write_cfg(CFG_NUM_DIMS, nd_val);
      dims = eff_size(nd_val);
      idling_on = (p != PHASES - 1) && (p % 3 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (!long_done || r >= 98) begin
          // Long run of extreme coordinates drives the distances toward saturation.
          n = $urandom_range(40, 72);
          for (int i = 0; i < n; i++)
            send_item(MODE_SAMPLE, rnd4(), $urandom_range(0, dims - 1),
                      $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, i == n - 1, 1'b0, '0);
          long_done = 1'b1;
          sent += n;
        end else if (r < 60) begin
          rot = $urandom_range(0, dims - 1);
          for (int i = 0; i < dims; i++) begin
            if (dims < NDM && $urandom_range(0, 7) == 0)
              send_item(MODE_SAMPLE, rnd4(), $urandom_range(dims, NDM - 1), pick_coord(),
                        1'b0, 1'b0, '0);
            send_item(MODE_SAMPLE, rnd4(), (i + rot) % dims, pick_coord(), i == dims - 1,
                      1'b0, '0);
          end
          sent += dims;
        end else if (r < 72) begin
          send_item(MODE_LOAD, rnd4(), rnd4(), pick_coord(), $urandom_range(0, 1), 1'b0, '0);
          sent++;
        end else if (r < 84) begin
          send_item(MODE_READ, rnd4(), rnd4(), pick_coord(), $urandom_range(0, 1), 1'b0, '0);
          sent++;
        end else if (r < 86) begin
          send_item(MODE_CLEAR, rnd4(), rnd4(), pick_coord(), $urandom_range(0, 1), 1'b0, '0);
          sent++;
        end else if (r < 94) begin
          // Sample closed early, dimensions repeated or missing.
          n = $urandom_range(1, dims);
          for (int i = 0; i < n; i++)
            send_item(MODE_SAMPLE, rnd4(), $urandom_range(0, dims - 1), pick_coord(),
                      i == n - 1, 1'b0, '0);
          sent += n;
        end else if (dims < NDM) begin
          send_item(MODE_SAMPLE, rnd4(), $urandom_range(dims, NDM - 1), pick_coord(),
                    $urandom_range(0, 1), 1'b0, '0);
        end else begin
          send_item(MODE_SAMPLE, rnd4(), $urandom_range(0, dims - 1), pick_coord(), 1'b0,
                    1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 39) == 0) drain_block();
      end
    end

    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
